// File: design/assert_macros.svh
// Assertion macros used by the radix digit converter controller RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising clock edge outside reset.
`define RDC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check that a condition never occurs outside reset.
`define RDC_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define RDC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RDC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: design/rdc_pkg.sv
// Package for the radix digit converter: field widths and the command/status
// structs between controller and datapath. No dependencies.
package rdc_pkg;

    localparam int VALUE_W    = 31;
    localparam int BASE_W     = 6;
    localparam int DIGIT_W    = 6;
    localparam int POS_W      = 5;
    localparam int MAX_DIGITS = 31;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int IN_DATA_W  = ((VALUE_W + BASE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((DIGIT_W + POS_W + 7) / 8) * 8;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture value and base, clear position
        logic div_start;   // clear remainder and bit counter
        logic div_step;    // one restoring-division step
        logic emit_digit;  // present remainder at current position, advance position
        logic emit_last;   // present final digit
        logic emit_err;    // present error word
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic base_bad;    // base outside 2..36
        logic n_lt_b;      // running quotient below base
        logic at_max;      // position reached the last allowed digit
        logic div_last;    // current division step is the final one
        logic out_free;    // output register can take a word this cycle
    } t_dp_stat;

endpackage

// File: design/rdc_datapath.sv
// Datapath of the radix digit converter: running quotient, bit-serial
// restoring divider, position counter and output register. Uses rdc_pkg.
module rdc_datapath
    import rdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [VALUE_W-1:0]   i_value,
    input  logic [BASE_W-1:0]    i_base,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [DIGIT_W-1:0]   o_digit,
    output logic [POS_W-1:0]     o_pos,
    output logic                 o_last,
    output logic                 o_error
);

    logic [VALUE_W-1:0] r_n;
    logic [BASE_W-1:0]  r_b;
    logic [BASE_W-1:0]  r_rem;
    logic [POS_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic [DIGIT_W-1:0] r_out_digit;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_last;
    logic               r_out_err;

    logic [BASE_W:0]    rem_shift;
    logic [BASE_W:0]    rem_diff;
    logic               rem_ge;
    logic [DIGIT_W-1:0] last_digit;

    always_comb begin
        rem_shift = {r_rem, r_n[VALUE_W-1]};
        rem_diff  = rem_shift - {1'b0, r_b};
        rem_ge    = rem_shift >= {1'b0, r_b};
        // saturate when the digit budget runs out before the quotient is small
        if (r_n >= VALUE_W'(r_b)) begin
            last_digit = DIGIT_W'(r_b - BASE_W'(1));
        end else begin
            last_digit = DIGIT_W'(r_n);
        end
    end

    assign o_stat.base_bad = (r_b < BASE_MIN) || (r_b > BASE_MAX);
    assign o_stat.n_lt_b   = r_n < VALUE_W'(r_b);
    assign o_stat.at_max   = r_pos == POS_W'(MAX_DIGITS - 1);
    assign o_stat.div_last = r_cnt == CNT_W'(VALUE_W - 1);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n   <= i_value;
            r_b   <= i_base;
            r_pos <= '0;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            // shift dividend out the top, quotient bit in at the bottom
            r_n   <= {r_n[VALUE_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_diff[BASE_W-1:0] : rem_shift[BASE_W-1:0];
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.emit_digit) begin
            r_pos <= r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_digit || i_cmd.emit_last || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_digit) begin
            r_out_digit <= DIGIT_W'(r_rem);
            r_out_pos   <= r_pos;
            r_out_last  <= 1'b0;
            r_out_err   <= 1'b0;
        end else if (i_cmd.emit_last) begin
            r_out_digit <= last_digit;
            r_out_pos   <= r_pos;
            r_out_last  <= 1'b1;
            r_out_err   <= 1'b0;
        end else if (i_cmd.emit_err) begin
            r_out_digit <= '0;
            r_out_pos   <= '0;
            r_out_last  <= 1'b1;
            r_out_err   <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_digit     = r_out_digit;
    assign o_pos       = r_out_pos;
    assign o_last      = r_out_last;
    assign o_error     = r_out_err;

endmodule

// File: design/rdc_ctrl.sv
// Controller of the radix digit converter: sequences load, division steps
// and output words. Uses rdc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rdc_ctrl
    import rdc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.base_bad) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_err = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_stat.n_lt_b || i_stat.at_max) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_last = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    n_state          = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `RDC_ASSERT(a_emit_needs_room, i_clk, i_rst_n, (o_cmd.emit_digit || o_cmd.emit_last || o_cmd.emit_err) |-> i_stat.out_free, "output word issued while output register full")
    `RDC_ASSERT(a_one_emit, i_clk, i_rst_n, $onehot0({o_cmd.emit_digit, o_cmd.emit_last, o_cmd.emit_err}), "more than one output word issued at once")
    `RDC_ASSERT(a_div_to_emit, i_clk, i_rst_n, (r_state == S_DIV && i_stat.div_last) |=> (r_state == S_EMIT), "division did not hand over to emit")
    `RDC_NEVER(a_load_busy, i_clk, i_rst_n, o_cmd.load && (o_cmd.div_step || o_cmd.emit_digit), "load overlaps work on a previous word")

endmodule

// File: design/radix_digit_converter_top.sv
// Top level of the radix digit converter: stream ports around the
// controller (rdc_ctrl) and datapath (rdc_datapath). Uses rdc_pkg.
//
// Usage:
//   Input channel s_axis_*: one word carries a 31-bit value and a 6-bit base.
//   Output channel m_axis_*: one word per digit, least significant first,
//   with its position; tlast marks the most significant digit. A base
//   outside 2..36 gives a single word with tuser (error) set, tlast set,
//   and digit and position zero.
//   One input word is worked on at a time; s_axis_tready is high only
//   while the block is idle.
//   Each non-final digit passes through a check state, a 31-step
//   bit-serial restoring division and an emit state; the final digit
//   is issued from the check state that follows.
//   An input gives at most 31 digits, as a 31-bit value in base 2 does.
//   Reset (i_rst_n low, synchronous) returns the controller to idle and
//   drops any pending output word.
//   When the receiver stalls, the output register holds its word and the
//   controller waits before presenting the next digit; no word is lost.
module radix_digit_converter_top
    import rdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [30:0] value, [36:31] base, rest zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] digit, [10:6] digit_position, rest zero
    output logic                  m_axis_tlast,
    output logic                  m_axis_tuser    // [0] error
);

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   pos;
    logic               in_ready;

    // Controller: accepts a word only in idle, then drives divide/emit steps
    rdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: holds quotient, base, remainder, position and output word
    rdc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (s_axis_tdata[VALUE_W-1:0]),
        .i_base      (s_axis_tdata[VALUE_W+BASE_W-1:VALUE_W]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_digit     (digit),
        .o_pos       (pos),
        .o_last      (m_axis_tlast),
        .o_error     (m_axis_tuser)
    );

    assign s_axis_tready = in_ready;
    // Pack digit in the low bits, position above it, zero fill to bytes
    assign m_axis_tdata  = {{(OUT_DATA_W - DIGIT_W - POS_W){1'b0}}, pos, digit};

endmodule
